// File: rtl/nca_pkg.sv
`timescale 1ns / 1ps

package nca_pkg;

	localparam int NUM_CENTERS = 8;
	localparam int DIMENSIONS  = 4;

	localparam int TABLE_DEPTH = NUM_CENTERS * DIMENSIONS;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
	localparam int IDX_W       = $clog2(NUM_CENTERS);

	localparam int CLUSTER_W = 3;
	localparam int DIM_W     = 2;
	localparam int COORD_W   = 16;
	localparam int DIST_W    = 36;
	localparam int ACC_W     = 37;
	localparam int COUNT_W   = 20;
	localparam int ABS_W     = COORD_W;
	localparam int SQ_W      = 2 * ABS_W;
	localparam int CMP_W     = (IDX_W > CLUSTER_W) ? IDX_W : CLUSTER_W;

	localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};
	localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic KIND_CENTROID = 1'b0;
	localparam logic KIND_POINT    = 1'b1;

endpackage

// File: rtl/nearest_centroid_assign_unit.sv
`timescale 1ns / 1ps

// Nearest-centroid assignment for k-means. Centroid coordinates are loaded one
// transaction each (kind 0) and never raise in_stall. Point coordinates (kind 1) are
// processed by a single subtract / square / accumulate pipe that visits one
// centroid per cycle, so a point coordinate holds in_stall high from acceptance
// until the pipe has visited the last centroid; the last coordinate of a point
// then passes through the ST_FIN state to load the result register, and waits
// there while a previous result is still stalled. Ties go to the lowest
// centroid index, distances are exact squared sums saturated to 36 bits, and
// changed_count counts changed points in the pass and clears after a point
// marked last_point. Table entries never written read as unknown values.
module nearest_centroid_assign_unit
	import nca_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [CLUSTER_W-1:0]        centroid_index,
	input  logic [DIM_W-1:0]            dim_index,
	input  logic signed [COORD_W-1:0]   coordinate,
	input  logic [CLUSTER_W-1:0]        previous_cluster,
	input  logic                        last_coordinate,
	input  logic                        last_point,

	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [CLUSTER_W-1:0]        best_cluster,
	output logic [DIST_W-1:0]           min_sq_distance,
	output logic                        changed,
	output logic [COUNT_W-1:0]          changed_count
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [COORD_W-1:0] table_mem [TABLE_DEPTH];

	logic                    in_acc;
	logic                    wr_en;
	logic [TABLE_AW-1:0]     wr_addr;
	logic [TABLE_AW-1:0]     rd_addr;

	// latched point transaction
	logic [COORD_W-1:0]      coord_q;
	logic [DIM_W-1:0]        dim_q;
	logic [CLUSTER_W-1:0]    prev_q;
	logic                    last_c_q;
	logic                    last_p_q;
	logic                    in_range_q;

	// issue sequencer
	logic [IDX_W-1:0]        iss_q;
	logic                    iss_end_q;
	logic                    issuing;

	// pipe stages
	logic                    v_s1, v_s2, v_s3;
	logic [IDX_W-1:0]        idx_s1, idx_s2, idx_s3;
	logic [COORD_W-1:0]      rd_s1;
	logic [ABS_W-1:0]        abs_s2;
	logic [SQ_W-1:0]         sq_s3;

	logic [ACC_W-1:0]        acc_q [NUM_CENTERS];
	logic [ACC_W-1:0]        best_d_q;
	logic [IDX_W-1:0]        best_q;
	logic [COUNT_W-1:0]      cnt_q;

	logic                    out_valid_q;

	logic signed [COORD_W:0] diff;
	logic [ABS_W-1:0]        diff_abs;
	logic [ACC_W:0]          acc_sum;
	logic [ACC_W-1:0]        acc_sat;
	logic [ACC_W-1:0]        acc_new;
	logic [CMP_W-1:0]        best_ext;
	logic [CMP_W-1:0]        prev_ext;
	logic                    chg;
	logic [COUNT_W-1:0]      cnt_inc;
	logic                    can_load;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign issuing  = (state_q == ST_RUN) && !iss_end_q;

	assign wr_en   = in_acc && (kind == KIND_CENTROID)
		&& (32'(centroid_index) < NUM_CENTERS) && (32'(dim_index) < DIMENSIONS);
	assign wr_addr = TABLE_AW'(32'(centroid_index) * DIMENSIONS + 32'(dim_index));
	assign rd_addr = TABLE_AW'(32'(iss_q) * DIMENSIONS + 32'(dim_q));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= coordinate;
		end
		rd_s1 <= table_mem[rd_addr];
	end

	assign diff     = $signed({coord_q[COORD_W-1], coord_q}) - $signed({rd_s1[COORD_W-1], rd_s1});
	assign diff_abs = diff[COORD_W] ? ABS_W'(-diff) : ABS_W'(diff);

	always_ff @(posedge clk) begin
		abs_s2 <= diff_abs;
		sq_s3  <= abs_s2 * abs_s2;
		if (in_acc && kind == KIND_POINT) begin
			coord_q    <= coordinate;
			dim_q      <= dim_index;
			prev_q     <= previous_cluster;
			last_c_q   <= last_coordinate;
			last_p_q   <= last_point;
			in_range_q <= (32'(dim_index) < DIMENSIONS);
		end
	end

	// saturating accumulate; out-of-range dimension adds nothing
	assign acc_sum = {1'b0, acc_q[idx_s3]} + (ACC_W + 1)'(sq_s3);
	assign acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
	assign acc_new = in_range_q ? acc_sat : acc_q[idx_s3];

	assign best_ext = CMP_W'(best_q);
	assign prev_ext = CMP_W'(prev_q);
	assign chg      = (best_ext != prev_ext);
	assign cnt_inc  = (chg && cnt_q != COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
	assign can_load = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			iss_q           <= '0;
			iss_end_q       <= 1'b1;
			v_s1            <= 1'b0;
			v_s2            <= 1'b0;
			v_s3            <= 1'b0;
			idx_s1          <= '0;
			idx_s2          <= '0;
			idx_s3          <= '0;
			for (int i = 0; i < NUM_CENTERS; i++) begin
				acc_q[i] <= '0;
			end
			best_d_q        <= '0;
			best_q          <= '0;
			cnt_q           <= '0;
			out_valid_q     <= 1'b0;
			best_cluster    <= '0;
			min_sq_distance <= '0;
			changed         <= 1'b0;
			changed_count   <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end

			v_s1   <= issuing;
			idx_s1 <= iss_q;
			v_s2   <= v_s1;
			idx_s2 <= idx_s1;
			v_s3   <= v_s2;
			idx_s3 <= idx_s2;

			if (issuing) begin
				if (iss_q == IDX_W'(NUM_CENTERS - 1)) begin
					iss_end_q <= 1'b1;
				end else begin
					iss_q <= iss_q + 1'b1;
				end
			end

			if (v_s3) begin
				// accumulators clear once a point is done
				acc_q[idx_s3] <= last_c_q ? '0 : acc_new;
				if (idx_s3 == '0 || acc_new < best_d_q) begin
					best_d_q <= acc_new;
					best_q   <= idx_s3;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && kind == KIND_POINT) begin
						state_q   <= ST_RUN;
						iss_q     <= '0;
						iss_end_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (v_s3 && idx_s3 == IDX_W'(NUM_CENTERS - 1)) begin
						state_q <= last_c_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					if (can_load) begin
						out_valid_q     <= 1'b1;
						best_cluster    <= best_ext[CLUSTER_W-1:0];
						min_sq_distance <= best_d_q[ACC_W-1] ? DIST_MAX : best_d_q[DIST_W-1:0];
						changed         <= chg;
						changed_count   <= cnt_inc;
						cnt_q           <= last_p_q ? '0 : cnt_inc;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// no work in flight while the input side is open
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(v_s1 || v_s2 || v_s3 || issuing))
		else $error("pipe busy while idle");

	// result stage only follows the last coordinate of a point
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> last_c_q)
		else $error("result stage without last coordinate");

	// a changed point is always counted
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && changed) |-> (changed_count != '0))
		else $error("changed point not counted");

	// a new result is loaded only when the output register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && out_stall) |=> (state_q == ST_FIN))
		else $error("result overwritten while stalled");

endmodule
